// ----- sv/wssm_pkg.sv -----
// ----------------------------------------------------------------------------
// wssm_pkg
// shared constants, register indexes and controller/datapath signal groups
// ----------------------------------------------------------------------------
package wssm_pkg;

    // capacity of one measurement window
    localparam int WINDOW_MAX = 256;
    localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W     = $clog2(WINDOW_MAX);

    // field widths
    localparam int ADDR_W   = 32;
    localparam int PSIZE_W  = 17;
    localparam int WSIZE_W  = 9;
    localparam int OUT_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b1;

    // reset values of the configuration registers
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = PSIZE_W'(4096);
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = WSIZE_W'(16);

    // commands from the controller
    typedef struct packed {
        logic div_start;   // request accepted: load address, start divide
        logic scan_start;  // quotient ready: walk the stored pages
        logic commit;      // update counters, store page, maybe close window
    } t_ctrl_cmd;

    // status back to the controller
    typedef struct packed {
        logic div_busy;
        logic scan_busy;
        logic close;       // this request closes the window
        logic out_free;    // output register can take a result now
    } t_ctrl_sts;

endpackage

// ----- sv/wssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wssm_ctrl
// sequencer: accept, divide, scan stored pages, commit
// ----------------------------------------------------------------------------
module wssm_ctrl
    import wssm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd,
    output logic      o_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.scan_busy) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                // a closing request waits for room in the output register
                if (!i_sts.close || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ----- sv/wssm_dp.sv -----
// ----------------------------------------------------------------------------
// wssm_dp
// datapath: config registers, serial divider, page store, counters, output
// ----------------------------------------------------------------------------
module wssm_dp
    import wssm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PSIZE_W-1:0]   i_cfg_data,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic                 i_end_of_trace,
    input  logic                 i_stall,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_sts            o_sts,
    output logic                 o_valid,
    output logic [OUT_W-1:0]     o_distinct_pages,
    output logic [OUT_W-1:0]     o_window_accesses
);

    localparam logic [COUNT_W-1:0]   WIN_MAX_C = COUNT_W'(WINDOW_MAX);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(ADDR_W);

    // config
    logic [PSIZE_W-1:0] r_page_size;
    logic [WSIZE_W-1:0] r_window_size;

    // divider
    logic [ADDR_W-1:0]    r_quo;
    logic [PSIZE_W-1:0]   r_rem;
    logic [PSIZE_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_last;
    logic [PSIZE_W:0]     rem_sh;
    logic                 rem_ge;

    // page store and scan
    logic [ADDR_W-1:0]    r_pages [WINDOW_MAX];
    logic [ADDR_W-1:0]    r_rd_data;
    logic                 r_rd_pend;
    logic                 r_scan_busy;
    logic                 r_hit;
    logic [COUNT_W-1:0]   r_idx;
    logic                 hit_now;
    logic                 rd_en;

    // window counters
    logic [COUNT_W-1:0] r_acc;
    logic [COUNT_W-1:0] r_dist;
    logic [COUNT_W-1:0] n_acc;
    logic [COUNT_W-1:0] n_dist;
    logic [COUNT_W-1:0] eff_win;
    logic               is_new;
    logic               close;

    // output register
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_dist;
    logic [OUT_W-1:0] r_out_acc;
    logic             out_free;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size   <= PAGE_SIZE_RST;
            r_window_size <= WINDOW_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PAGE_SIZE:   r_page_size   <= i_cfg_data;
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WSIZE_W-1:0];
            endcase
        end
    end

    // restoring divide, one quotient bit a cycle
    assign rem_sh = {r_rem, r_quo[ADDR_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= DIV_STEPS;
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= i_address;
            r_rem  <= '0;
            r_div  <= (r_page_size == '0) ? PSIZE_W'(1) : r_page_size;
            r_last <= i_end_of_trace;
        end else if (r_div_cnt != '0) begin
            r_quo <= {r_quo[ADDR_W-2:0], rem_ge};
            r_rem <= rem_ge ? PSIZE_W'(rem_sh - {1'b0, r_div}) : rem_sh[PSIZE_W-1:0];
        end
    end

    // linear scan of the stored pages, one read a cycle
    assign hit_now = r_rd_pend && (r_rd_data == r_quo);
    assign rd_en   = r_scan_busy && !hit_now && (r_idx < r_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_idx       <= '0;
        end else if (i_cmd.scan_start) begin
            r_scan_busy <= 1'b1;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_idx       <= '0;
        end else if (r_scan_busy) begin
            if (hit_now) begin
                r_hit       <= 1'b1;
                r_scan_busy <= 1'b0;
                r_rd_pend   <= 1'b0;
            end else if (rd_en) begin
                r_rd_pend <= 1'b1;
                r_idx     <= r_idx + 1'b1;
            end else begin
                r_scan_busy <= 1'b0;
                r_rd_pend   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_pages[r_idx[SLOT_W-1:0]];
        end
        if (i_cmd.commit && is_new) begin
            r_pages[r_dist[SLOT_W-1:0]] <= r_quo;
        end
    end

    // window bookkeeping
    always_comb begin
        if (r_window_size == '0) begin
            eff_win = COUNT_W'(1);
        end else if (COUNT_W'(r_window_size) > WIN_MAX_C) begin
            eff_win = WIN_MAX_C;
        end else begin
            eff_win = COUNT_W'(r_window_size);
        end
    end

    assign is_new = !r_hit && (r_dist < WIN_MAX_C);
    assign n_dist = is_new ? r_dist + 1'b1 : r_dist;
    assign n_acc  = (r_acc < WIN_MAX_C) ? r_acc + 1'b1 : r_acc;
    assign close  = (n_acc >= eff_win) || r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_dist <= '0;
        end else if (i_cmd.commit) begin
            if (close) begin
                r_acc  <= '0;
                r_dist <= '0;
            end else begin
                r_acc  <= n_acc;
                r_dist <= n_dist;
            end
        end
    end

    // output register
    assign out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit && close) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && close) begin
            r_out_dist <= OUT_W'(n_dist);
            r_out_acc  <= OUT_W'(n_acc);
        end
    end

    assign o_valid           = r_out_vld;
    assign o_distinct_pages  = r_out_dist;
    assign o_window_accesses = r_out_acc;

    assign o_sts.div_busy  = (r_div_cnt != '0);
    assign o_sts.scan_busy = r_scan_busy;
    assign o_sts.close     = close;
    assign o_sts.out_free  = out_free;

    // a window never holds more distinct pages than accesses
    a_dist_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= r_acc)
        else $error("distinct count exceeds access count");

    // commit only once divide and scan are finished
    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_div_cnt == '0) && !r_scan_busy)
        else $error("commit while divide or scan busy");

    // a closing commit never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && close) |-> out_free)
        else $error("result overwritten");

    // divide start loads the full step count
    a_div_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_div_cnt == DIV_STEPS))
        else $error("divider not started");

endmodule

// ----- sv/working_set_size_monitor.sv -----
// a request passes accept, a bit-serial divide by page size, a page-store scan and commit;
//   the scan reads the d distinct pages already held in the window (0 to 255), fewer on a hit,
//   and the next request is accepted only after the commit
// results leave through an output register, so a stalled result blocks only a closing request
// reset: synchronous active low; counters cleared, page size 4096, window size 16
// ----------------------------------------------------------------------------
// working_set_size_monitor
// fixed-window working-set measurement: counts distinct pages per window
// ----------------------------------------------------------------------------
module working_set_size_monitor
    import wssm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PSIZE_W-1:0]   i_cfg_data,
    // access requests
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ADDR_W-1:0]    i_address,
    input  logic                 i_end_of_trace,
    // window results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_distinct_pages,
    output logic [OUT_W-1:0]     o_window_accesses
);

    // controller to datapath commands and status
    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // sequencer: one request at a time through divide, scan and commit
    wssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // datapath: divider, page store, window counters and result register
    wssm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_address         (i_address),
        .i_end_of_trace    (i_end_of_trace),
        .i_stall           (i_stall),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_distinct_pages  (o_distinct_pages),
        .o_window_accesses (o_window_accesses)
    );

endmodule
